/* hw/rtl/brl_pkg.sv */
// Shared types, constants and helper functions for the button remap learner.
// No dependencies; used by brl_step and button_remap_learner_unit.
package brl_pkg;

    // Pad layout
    localparam int PAD_COUNT    = 13;
    localparam int ACTION_BASE  = 4;
    localparam int ACTION_COUNT = 6;
    localparam int B_DOWN       = 1;
    localparam int B_H1         = 4;
    localparam int B_H2         = 5;
    localparam int B_H3         = 6;
    localparam int B_START      = 10;
    localparam int B_SELECT     = 11;

    // Field widths
    localparam int BUTTON_W  = 16;
    localparam int TIME_W    = 32;
    localparam int PERIOD_W  = 16;
    localparam int TOGGLE_W  = 8;
    localparam int MAP_W     = 4;
    localparam int POS_W     = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_TOGGLES = 2'd2;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST  = 16'd300;
    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST  = 16'd100;
    localparam logic [TOGGLE_W-1:0] FAST_TOGGLES_RST = 8'd12;

    typedef logic [ACTION_COUNT-1:0][MAP_W-1:0] map_t;

    typedef struct packed {
        map_t                      button_map;
        logic [ACTION_COUNT-1:0]   used_marks;
        logic [POS_W-1:0]          learn_position;
        logic                      learning_flag;
        logic                      waiting_release;
        logic                      slow_level;
        logic [TIME_W-1:0]         slow_mark;
        logic                      fast_on;
        logic                      fast_level;
        logic [TOGGLE_W-1:0]       fast_count;
        logic [TIME_W-1:0]         fast_mark;
        logic                      chord_latched;
    } brl_state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] slow_period;
        logic [PERIOD_W-1:0] fast_period;
        logic [TOGGLE_W-1:0] fast_toggles;
    } brl_cfg_t;

    typedef struct packed {
        logic [BUTTON_W-1:0] logical_buttons;
        logic                learning_active;
        logic [POS_W-1:0]    learning_index;
        logic                reset_feedback_active;
    } brl_result_t;

    // Each action slot mapped to its own physical button
    function automatic map_t identity_map();
        map_t m;
        for (int k = 0; k < ACTION_COUNT; k++)
        begin
            m[k] = MAP_W'(ACTION_BASE + k);
        end
        return m;
    endfunction

    // Learner state after reset: identity map, everything else cleared
    function automatic brl_state_t reset_state();
        brl_state_t s;
        s            = '0;
        s.button_map = identity_map();
        return s;
    endfunction

    // Output slot learned at each step: B1,B2,B4,B5,B3,B6
    function automatic logic [POS_W-1:0] learn_order(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] slot;
        unique case (pos)
            3'd0:    slot = 3'd0;
            3'd1:    slot = 3'd1;
            3'd2:    slot = 3'd3;
            3'd3:    slot = 3'd4;
            3'd4:    slot = 3'd2;
            default: slot = 3'd5;
        endcase
        return slot;
    endfunction

endpackage

/* hw/rtl/button_remap_learner_unit.sv */
// An accepted scan's result is registered and shows on m_axis in the next cycle.
// Throughput: one scan per cycle; s_axis_tready drops only while a result
// waits in the output register and m_axis_tready is low.
// Reset (rst_n low, asynchronous): identity map, learning and blink idle,
// blink periods 300 ms / 100 ms, 12 fast toggles, no result pending.
// Top level of the button remap learner; depends on brl_pkg and brl_step.
module button_remap_learner_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // [15:0] raw_buttons, [47:16] now_ms
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [brl_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [15:0] logical_buttons, [16] learning_active, [19:17] learning_index,
    // [20] reset_feedback_active, [23:21] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [brl_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [brl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [brl_pkg::PERIOD_W-1:0]         cfg_data
);

    brl_pkg::brl_state_t  state_reg;
    brl_pkg::brl_state_t  state_next;
    brl_pkg::brl_cfg_t    cfg_reg;
    brl_pkg::brl_result_t result;
    brl_pkg::brl_result_t out_data_reg;
    logic                 out_valid_reg;
    logic                 in_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Per-scan logic
    brl_step u_step
    (
        .state       (state_reg),
        .cfg         (cfg_reg),
        .raw_buttons (s_axis_tdata[15:0]),
        .now_ms      (s_axis_tdata[47:16]),
        .state_next  (state_next),
        .result      (result)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_period  <= brl_pkg::SLOW_PERIOD_RST;
            cfg_reg.fast_period  <= brl_pkg::FAST_PERIOD_RST;
            cfg_reg.fast_toggles <= brl_pkg::FAST_TOGGLES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                brl_pkg::CFG_SLOW_PERIOD:  cfg_reg.slow_period  <= cfg_data;
                brl_pkg::CFG_FAST_PERIOD:  cfg_reg.fast_period  <= cfg_data;
                brl_pkg::CFG_FAST_TOGGLES: cfg_reg.fast_toggles <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    // Learner state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brl_pkg::reset_state();
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg.reset_feedback_active,
                            out_data_reg.learning_index, out_data_reg.learning_active,
                            out_data_reg.logical_buttons};

    // Checks
    a_no_accept_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("item accepted while result stalled");

    a_modes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[16] && m_axis_tdata[20]))
        else $error("learning and restore feedback both active");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.learn_position <= 3'd6)
        else $error("learn position out of range");

    a_high_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:13] == 3'b000))
        else $error("unused logical bits set");

endmodule

/* hw/rtl/brl_step.sv */
// Next-state and result logic for one button scan.
// Depends on brl_pkg.
module brl_step
(
    input  brl_pkg::brl_state_t               state,
    input  brl_pkg::brl_cfg_t                 cfg,
    input  logic [brl_pkg::BUTTON_W-1:0]      raw_buttons,
    input  logic [brl_pkg::TIME_W-1:0]        now_ms,
    output brl_pkg::brl_state_t               state_next,
    output brl_pkg::brl_result_t              result
);

    always_comb
    begin
        logic [brl_pkg::PAD_COUNT-1:0] raw;
        logic [brl_pkg::BUTTON_W-1:0]  raw_wide;
        logic                          base;
        logic                          restore;
        logic                          learn_chord;
        logic                          released;
        logic [brl_pkg::TIME_W-1:0]    slow_diff;
        logic [brl_pkg::TIME_W-1:0]    fast_diff;
        logic                          found;
        logic [brl_pkg::POS_W-1:0]     found_idx;
        logic [brl_pkg::POS_W-1:0]     pos_inc;
        logic [brl_pkg::BUTTON_W-1:0]  logical;
        brl_pkg::brl_state_t           nxt;

        raw      = raw_buttons[brl_pkg::PAD_COUNT-1:0];
        raw_wide = brl_pkg::BUTTON_W'(raw);
        nxt      = state;

        base = raw[brl_pkg::B_START] & raw[brl_pkg::B_SELECT] &
               raw[brl_pkg::B_H1] & raw[brl_pkg::B_H2] & raw[brl_pkg::B_H3];
        restore     = base & raw[brl_pkg::B_DOWN];
        learn_chord = base & ~raw[brl_pkg::B_DOWN];
        released = ~(raw[brl_pkg::B_START] | raw[brl_pkg::B_SELECT] |
                     raw[brl_pkg::B_H1] | raw[brl_pkg::B_H2] | raw[brl_pkg::B_H3]);

        // First pressed, still unused action button, lowest index wins
        found     = 1'b0;
        found_idx = '0;
        for (int k = brl_pkg::ACTION_COUNT - 1; k >= 0; k--)
        begin
            if (raw[brl_pkg::ACTION_BASE + k] && !state.used_marks[k])
            begin
                found     = 1'b1;
                found_idx = brl_pkg::POS_W'(k);
            end
        end

        slow_diff = now_ms - state.slow_mark;
        pos_inc   = state.learn_position + 3'd1;

        if (state.learning_flag)
        begin
            // Slow START blink while learning
            if (slow_diff >= brl_pkg::TIME_W'(cfg.slow_period))
            begin
                nxt.slow_mark  = now_ms;
                nxt.slow_level = ~state.slow_level;
            end
            if (state.waiting_release)
            begin
                if (released)
                begin
                    nxt.waiting_release = 1'b0;
                end
            end
            else if (found)
            begin
                if (state.learn_position < brl_pkg::POS_W'(brl_pkg::ACTION_COUNT))
                begin
                    nxt.button_map[brl_pkg::learn_order(state.learn_position)] =
                        brl_pkg::MAP_W'(brl_pkg::ACTION_BASE) + brl_pkg::MAP_W'(found_idx);
                end
                nxt.used_marks[found_idx] = 1'b1;
                nxt.learn_position        = pos_inc;
                if (pos_inc >= brl_pkg::POS_W'(brl_pkg::ACTION_COUNT))
                begin
                    nxt.learning_flag   = 1'b0;
                    nxt.slow_level      = 1'b0;
                    nxt.waiting_release = 1'b0;
                end
            end
        end
        else
        begin
            // Chord detection, acting once per press
            if (!restore && !learn_chord)
            begin
                nxt.chord_latched = 1'b0;
            end
            else if (!state.chord_latched)
            begin
                nxt.chord_latched = 1'b1;
                if (restore)
                begin
                    nxt.button_map      = brl_pkg::identity_map();
                    nxt.learning_flag   = 1'b0;
                    nxt.learn_position  = '0;
                    nxt.waiting_release = 1'b0;
                    nxt.slow_level      = 1'b0;
                    nxt.fast_on         = 1'b1;
                    nxt.fast_level      = 1'b0;
                    nxt.fast_count      = '0;
                    nxt.fast_mark       = now_ms;
                end
                else
                begin
                    nxt.learning_flag   = 1'b1;
                    nxt.learn_position  = '0;
                    nxt.waiting_release = 1'b1;
                    nxt.slow_mark       = now_ms;
                    nxt.slow_level      = 1'b0;
                    nxt.fast_on         = 1'b0;
                    nxt.fast_level      = 1'b0;
                    nxt.used_marks      = '0;
                end
            end
        end

        // Fast START blink after a restore, on the updated mark
        fast_diff = now_ms - nxt.fast_mark;
        if (nxt.fast_on && (fast_diff >= brl_pkg::TIME_W'(cfg.fast_period)))
        begin
            nxt.fast_mark  = now_ms;
            nxt.fast_level = ~nxt.fast_level;
            nxt.fast_count = nxt.fast_count + 8'd1;
            if (nxt.fast_count >= cfg.fast_toggles)
            begin
                nxt.fast_on    = 1'b0;
                nxt.fast_level = 1'b0;
            end
        end

        // Logical vector through the updated map
        logical = raw_wide;
        for (int k = 0; k < brl_pkg::ACTION_COUNT; k++)
        begin
            logical[brl_pkg::ACTION_BASE + k] = raw_wide[nxt.button_map[k]];
        end
        if (nxt.learning_flag)
        begin
            logical[brl_pkg::B_START] = nxt.slow_level;
        end
        else if (nxt.fast_on)
        begin
            logical[brl_pkg::B_START] = nxt.fast_level;
        end

        state_next                   = nxt;
        result.logical_buttons       = logical;
        result.learning_active       = nxt.learning_flag;
        result.learning_index        = nxt.learn_position;
        result.reset_feedback_active = nxt.fast_on;
    end

endmodule

/* tb/brl_scan_checker.sv */
`timescale 1ns / 100ps
// Result checker for the button remap learner: follows scans, register writes
// and results on the block's ports, predicts each result and compares it.
// Depends on brl_pkg only; instantiated beside the block by tb_top.
module brl_scan_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            scan_valid,
    input  logic                            scan_ready,
    input  logic [brl_pkg::IN_DATA_W-1:0]   scan_data,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic [brl_pkg::OUT_DATA_W-1:0]  res_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [brl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [brl_pkg::PERIOD_W-1:0]    cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_checked,
    output int                              sessions_done,
    output int                              restores_seen
);
    import brl_pkg::*;

    // mirrored registers
    logic [PERIOD_W-1:0] slow_per;
    logic [PERIOD_W-1:0] fast_per;
    logic [TOGGLE_W-1:0] fb_limit;

    // predicted block state
    logic [MAP_W-1:0]        slot_src [ACTION_COUNT];
    logic [ACTION_COUNT-1:0] taken;
    logic [POS_W-1:0]        pick_pos;
    logic                    learning;
    logic                    wait_release;
    logic                    slow_lvl;
    logic [TIME_W-1:0]       slow_mark;
    logic                    fb_on;
    logic                    fb_lvl;
    logic [TOGGLE_W-1:0]     fb_count;
    logic [TIME_W-1:0]       fb_mark;
    logic                    chord_held;

    brl_result_t pending_results [$];

    int n_bad      = 0;
    int n_checked  = 0;
    int n_sessions = 0;
    int n_restores = 0;

    // output slot filled by the n-th learned button: B1,B2,B4,B5,B3,B6
    function automatic int slot_for_pick(input logic [POS_W-1:0] pos);
        case (pos)
            3'd0:    return 0;
            3'd1:    return 1;
            3'd2:    return 3;
            3'd3:    return 4;
            3'd4:    return 2;
            default: return 5;
        endcase
    endfunction

    task automatic clear_model();
        for (int k = 0; k < ACTION_COUNT; k++)
        begin
            slot_src[k] = MAP_W'(ACTION_BASE + k);
        end
        slow_per     = SLOW_PERIOD_RST;
        fast_per     = FAST_PERIOD_RST;
        fb_limit     = FAST_TOGGLES_RST;
        taken        = '0;
        pick_pos     = '0;
        learning     = 1'b0;
        wait_release = 1'b0;
        slow_lvl     = 1'b0;
        slow_mark    = '0;
        fb_on        = 1'b0;
        fb_lvl       = 1'b0;
        fb_count     = '0;
        fb_mark      = '0;
        chord_held   = 1'b0;
    endtask

    // One scan through the predictor: state update, then the remapped view
    task automatic remap_scan(input logic [BUTTON_W-1:0] raw, input logic [TIME_W-1:0] now,
                              output brl_result_t res);
        logic [PAD_COUNT-1:0] pad;
        logic                 chord_base;
        logic [BUTTON_W-1:0]  view;
        int                   pick;
        pad = raw[PAD_COUNT-1:0];
        chord_base = pad[B_START] & pad[B_SELECT] & pad[B_H1] & pad[B_H2] & pad[B_H3];
        pick = -1;
        if (learning)
        begin
            // slow blink runs through the whole session, release wait included
            if (TIME_W'(now - slow_mark) >= TIME_W'(slow_per))
            begin
                slow_mark = now;
                slow_lvl  = ~slow_lvl;
            end
            if (wait_release)
            begin
                if (!(pad[B_START] | pad[B_SELECT] | pad[B_H1] | pad[B_H2] | pad[B_H3]))
                    wait_release = 1'b0;
            end
            else
            begin
                for (int k = ACTION_COUNT - 1; k >= 0; k--)
                begin
                    if (pad[ACTION_BASE + k] && !taken[k])
                        pick = k;
                end
                if (pick >= 0)
                begin
                    if (pick_pos < ACTION_COUNT)
                        slot_src[slot_for_pick(pick_pos)] = MAP_W'(ACTION_BASE + pick);
                    taken[pick] = 1'b1;
                    pick_pos    = pick_pos + 1'b1;
                    if (pick_pos >= ACTION_COUNT)
                    begin
                        learning     = 1'b0;
                        slow_lvl     = 1'b0;
                        wait_release = 1'b0;
                        n_sessions++;
                    end
                end
            end
        end
        else if (!chord_base)
        begin
            chord_held = 1'b0;
        end
        else if (!chord_held)
        begin
            chord_held = 1'b1;
            if (pad[B_DOWN])
            begin
                // restore chord: identity map and fast feedback blink
                for (int k = 0; k < ACTION_COUNT; k++)
                begin
                    slot_src[k] = MAP_W'(ACTION_BASE + k);
                end
                learning     = 1'b0;
                pick_pos     = '0;
                wait_release = 1'b0;
                slow_lvl     = 1'b0;
                fb_on        = 1'b1;
                fb_lvl       = 1'b0;
                fb_count     = '0;
                fb_mark      = now;
                n_restores++;
            end
            else
            begin
                learning     = 1'b1;
                pick_pos     = '0;
                wait_release = 1'b1;
                slow_mark    = now;
                slow_lvl     = 1'b0;
                fb_on        = 1'b0;
                fb_lvl       = 1'b0;
                taken        = '0;
            end
        end

        // fast feedback blink
        if (fb_on && TIME_W'(now - fb_mark) >= TIME_W'(fast_per))
        begin
            fb_mark  = now;
            fb_lvl   = ~fb_lvl;
            fb_count = fb_count + 1'b1;
            if (fb_count >= fb_limit)
            begin
                fb_on  = 1'b0;
                fb_lvl = 1'b0;
            end
        end

        view = '0;
        for (int i = 0; i < PAD_COUNT; i++)
        begin
            if (i == B_START && learning)
                view[i] = slow_lvl;
            else if (i == B_START && fb_on)
                view[i] = fb_lvl;
            else if (i >= ACTION_BASE && i < ACTION_BASE + ACTION_COUNT)
                view[i] = pad[slot_src[i - ACTION_BASE]];
            else
                view[i] = pad[i];
        end
        res.logical_buttons       = view;
        res.learning_active       = learning;
        res.learning_index        = pick_pos;
        res.reset_feedback_active = fb_on;
    endtask

    task automatic check_field(input string what, input logic [BUTTON_W-1:0] want,
                               input logic [BUTTON_W-1:0] got);
        if (want !== got)
        begin
            n_bad++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        brl_result_t want;
        brl_result_t got;
        if (!rst_n)
        begin
            clear_model();
            pending_results.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SLOW_PERIOD:  slow_per = cfg_data;
                    CFG_FAST_PERIOD:  fast_per = cfg_data;
                    CFG_FAST_TOGGLES: fb_limit = cfg_data[TOGGLE_W-1:0];
                    default:          ;
                endcase
            end

            // results leaving the block against the oldest prediction
            if (res_valid && res_ready)
            begin
                got.logical_buttons       = res_data[BUTTON_W-1:0];
                got.learning_active       = res_data[BUTTON_W];
                got.learning_index        = res_data[BUTTON_W+1 +: POS_W];
                got.reset_feedback_active = res_data[BUTTON_W+1+POS_W];
                if (pending_results.size() == 0)
                begin
                    n_bad++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, res_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    check_field("logical_buttons", want.logical_buttons,
                                got.logical_buttons);
                    check_field("learning_active", 16'(want.learning_active),
                                16'(got.learning_active));
                    check_field("learning_index", 16'(want.learning_index),
                                16'(got.learning_index));
                    check_field("reset_feedback_active", 16'(want.reset_feedback_active),
                                16'(got.reset_feedback_active));
                    check_field("tdata padding", 16'd0,
                                16'(res_data[OUT_DATA_W-1:BUTTON_W+2+POS_W]));
                end
            end

            // accepted scans
            if (scan_valid && scan_ready)
            begin
                remap_scan(scan_data[BUTTON_W-1:0], scan_data[BUTTON_W +: TIME_W], want);
                pending_results.push_back(want);
            end
        end
        mismatches      <= n_bad;
        outstanding     <= pending_results.size();
        results_checked <= n_checked;
        sessions_done   <= n_sessions;
        restores_seen   <= n_restores;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for button_remap_learner_unit: clock, reset, scan stimulus,
// result back-pressure, register writes and the verdict.
// Depends on brl_pkg, brl_scan_checker and the block itself.
module tb_top;
    import brl_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [BUTTON_W-1:0] LEARN_CHORD =
        (16'd1 << B_START) | (16'd1 << B_SELECT) | (16'd1 << B_H1) |
        (16'd1 << B_H2) | (16'd1 << B_H3);
    localparam logic [BUTTON_W-1:0] BTN_DOWN      = 16'd1 << B_DOWN;
    localparam logic [BUTTON_W-1:0] RESTORE_CHORD = LEARN_CHORD | BTN_DOWN;
    localparam logic [BUTTON_W-1:0] ACTION_MASK   =
        BUTTON_W'(((1 << ACTION_COUNT) - 1) << ACTION_BASE);

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = CFG_SLOW_PERIOD;
    logic [PERIOD_W-1:0]    cfg_data      = '0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   cfg_ready;

    int mismatches;
    int outstanding;
    int results_checked;
    int sessions_done;
    int restores_seen;

    logic [TIME_W-1:0] clock_ms    = '0;   // time stamp of the last scan sent
    logic              quiet_link  = 1'b0; // no idling on either side
    int                holdoff_req = 0;
    int                scans_sent  = 0;
    int                cycles      = 0;

    always
    begin
        #(CLK_HALF) clk = ~clk;
    end

    button_remap_learner_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    brl_scan_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .scan_valid      (s_axis_tvalid),
        .scan_ready      (s_axis_tready),
        .scan_data       (s_axis_tdata),
        .res_valid       (m_axis_tvalid),
        .res_ready       (m_axis_tready),
        .res_data        (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .sessions_done   (sessions_done),
        .restores_seen   (restores_seen)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int seen_req;
        seen_req = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holdoff_req != seen_req)
            begin
                seen_req = holdoff_req;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= quiet_link || ($urandom_range(99) >= 30);
                @(posedge clk);
            end
        end
    end

    // mostly small steps, sometimes long gaps or an arbitrary jump
    function automatic int unsigned pace_ms();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(40);
        else if (r < 85)
            return $urandom_range(400);
        else if (r < 97)
            return $urandom_range(70000);
        else
            return $urandom();
    endfunction

    function automatic logic [BUTTON_W-1:0] sparse_bits();
        return BUTTON_W'($urandom() & $urandom() & $urandom());
    endfunction

    task automatic send_scan(input logic [BUTTON_W-1:0] raw, input int unsigned step_ms);
        clock_ms = clock_ms + step_ms;
        s_axis_tdata  <= {clock_ms, raw};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        scans_sent++;
        if (!quiet_link && $urandom_range(99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // stop offering scans and let every result come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val,
                             input logic last);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [PERIOD_W-1:0] slow_p,
                                 input logic [PERIOD_W-1:0] fast_p,
                                 input logic [PERIOD_W-1:0] toggles);
        wait_drained();
        write_reg(CFG_SLOW_PERIOD, slow_p, 1'b0);
        write_reg(CFG_FAST_PERIOD, fast_p, 1'b0);
        write_reg(CFG_FAST_TOGGLES, toggles, 1'b1);
        @(posedge clk);
    endtask

    task automatic play_scans(input int n);
        repeat (n) send_scan(sparse_bits(), pace_ms());
    endtask

    task automatic noise_scans(input int n);
        repeat (n) send_scan(BUTTON_W'($urandom()), pace_ms());
    endtask

    task automatic restore_episode();
        repeat ($urandom_range(3, 1)) send_scan(RESTORE_CHORD | sparse_bits(), pace_ms());
        // release and press again while the feedback may still run
        if ($urandom_range(2) == 0)
        begin
            send_scan(sparse_bits() & ~LEARN_CHORD, pace_ms());
            send_scan(RESTORE_CHORD, pace_ms());
        end
        play_scans($urandom_range(30, 4));
    endtask

    // chord, release wait, then one button per pick in random order;
    // now and then the session is broken off half way
    task automatic learn_episode();
        int                  perm [ACTION_COUNT];
        int                  j;
        int                  tmp;
        int                  stop_at;
        logic [BUTTON_W-1:0] held;
        for (int k = 0; k < ACTION_COUNT; k++)
        begin
            perm[k] = k;
        end
        for (int k = ACTION_COUNT - 1; k > 0; k--)
        begin
            j       = $urandom_range(k);
            tmp     = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        stop_at = ($urandom_range(99) < 15) ? $urandom_range(ACTION_COUNT - 1) : ACTION_COUNT;

        repeat ($urandom_range(3, 1))
            send_scan(LEARN_CHORD | (sparse_bits() & ~BTN_DOWN), pace_ms());
        repeat ($urandom_range(3))
        begin
            held = LEARN_CHORD & BUTTON_W'($urandom());
            if (held == '0)
                held = LEARN_CHORD;
            send_scan(held | sparse_bits(), pace_ms());
        end
        send_scan(sparse_bits() & ~LEARN_CHORD, pace_ms());
        for (int k = 0; k < stop_at; k++)
        begin
            if ($urandom_range(3) == 0)
                send_scan(BUTTON_W'($urandom()), pace_ms());
            send_scan((16'd1 << (ACTION_BASE + perm[k])) | (sparse_bits() & ~ACTION_MASK),
                      pace_ms());
            if ($urandom_range(1) == 0)
                send_scan(sparse_bits() & ~ACTION_MASK, pace_ms());
        end
    endtask

    task automatic random_phase(input int n_scans);
        int goal;
        int r;
        goal = scans_sent + n_scans;
        while (scans_sent < goal)
        begin
            r = $urandom_range(99);
            if (r < 35)
                learn_episode();
            else if (r < 55)
                restore_episode();
            else if (r < 80)
                play_scans($urandom_range(20, 3));
            else
                noise_scans($urandom_range(12, 2));
        end
    endtask

    // hand-picked scans with the registers at their reset values
    task automatic directed_scans();
        send_scan(16'h0000, 0);
        send_scan(16'hFFFF, 7);                  // every bit: restore chord wins
        send_scan(16'hE000, 100);                // bits above the pad only
        send_scan(LEARN_CHORD, 50);              // learning starts, feedback stops
        send_scan(LEARN_CHORD | 16'h0001, 300);  // still held: waits for release
        send_scan(16'h0000, 10);
        send_scan(16'h0200, 5);                  // L3 becomes B1
        send_scan(16'h0060, 5);                  // H2 before H3
        send_scan(16'h0020, 5);                  // H2 already taken
        send_scan(16'h0380, 5);                  // L1 first of three
        send_scan(RESTORE_CHORD, 5);             // chords ignored while learning: H1 taken
        send_scan(16'h0040, 5);
        send_scan(16'h0100, 5);                  // sixth pick ends the session
        send_scan(ACTION_MASK, 5);
        send_scan(16'h0210, 5);
        clock_ms = 32'hFFFF_FF80;
        send_scan(LEARN_CHORD, 0);
        send_scan(16'h0000, 32'h7F);             // time stamp at its maximum
        send_scan(16'h0000, 32'h140);            // slow blink across the wrap
        send_scan(RESTORE_CHORD, 5);             // taken as H1 pick
        send_scan(16'h0000, 5);
    endtask

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_scans();

        load_settings(16'd1, 16'd1, 16'd1);
        random_phase(300);

        load_settings(16'hFFFF, 16'hFFFF, 16'h00FF);
        quiet_link = 1'b1;
        random_phase(300);
        quiet_link = 1'b0;

        // zero periods and zero toggle count
        load_settings(16'd0, 16'd0, 16'd0);
        random_phase(250);

        load_settings(16'($urandom_range(1000, 1)), 16'($urandom_range(500, 1)),
                      16'($urandom()));
        random_phase(150);
        holdoff_req = holdoff_req + 1;
        random_phase(250);

        load_settings(SLOW_PERIOD_RST, FAST_PERIOD_RST, 16'(FAST_TOGGLES_RST));
        random_phase(400);

        wait_drained();
        $display("%0d scans, %0d results checked, %0d sessions learned, %0d restores",
                 scans_sent, results_checked, sessions_done, restores_seen);
        $display("register sets: reset, minimum, maximum, zero and random; one long stall");
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/brl_pkg.sv
hw/rtl/brl_step.sv
hw/rtl/button_remap_learner_unit.sv
tb/brl_scan_checker.sv
tb/tb_top.sv
